// ===== rtl/nps_pkg.sv =====
package nps_pkg;

  // Defaults for the top-level parameters
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int COORD_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int ID_W     = 16;
  localparam int FIELD_W  = 16;
  localparam int DIST_W   = 33;
  localparam int STATUS_W = 2;

  // Command codes (s_tuser)
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Result status codes (m_tuser)
  localparam logic [STATUS_W-1:0] ST_ADDED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REPLACED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_QUERY    = 2'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } seq_state_t;

endpackage

// ===== rtl/nearest_point_search_core.sv =====
// Brute-force nearest point search over a table of up to TABLE_DEPTH points.
// Every insert or query walks the N stored entries through one RAM read port,
// one entry per cycle, into a four-stage distance/compare unit; the result
// beat is registered once the scan has drained, and waits while the previous
// result is still held.
// One item at a time: the next beat is taken the cycle after the result is
// registered.
// Synchronous reset empties the table (fill count to zero) and clears control.
module nearest_point_search_core
  import nps_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // point_id[15:0], x_coord[31:16], y_coord[47:32]
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // found[0], nearest_id[16:1], best_dist_sq[49:17], zero
  output logic [1:0]  m_tuser    // status
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CW    = COORD_WIDTH;
  localparam int EW    = ID_W + 2 * CW;
  localparam int SQW   = 2 * CW + 1;
  localparam int DW    = 2 * CW + 2;

  seq_state_t state, state_next;

  // Accepted item
  logic                 cmd_q;
  logic [ID_W-1:0]      id_q;
  logic signed [CW-1:0] x_q, y_q;
  logic [31:0]          x_raw, y_raw;

  // Table bookkeeping
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic             hit;
  logic [AW-1:0]    hit_idx;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic [ID_W-1:0]      rd_id;
  logic signed [CW-1:0] rd_x, rd_y;

  // Distance pipeline
  logic                 rd_v, d_v, s_v, t_v;
  logic [AW-1:0]        rd_addr_q;
  logic signed [CW:0]   dx, dy;
  logic [ID_W-1:0]      d_id, s_id, t_id;
  logic signed [DW-1:0] px, py;
  logic [SQW-1:0]       sqx, sqy;
  logic [DW-1:0]        sum;

  // Running best
  logic            found_q;
  logic [DW-1:0]   best;
  logic [ID_W-1:0] best_id;

  // Control outputs of the sequencer
  logic accept, issue, out_free, finish, room;

  // Coordinates are the low COORD_WIDTH bits of the field
  assign x_raw = 32'(s_tdata[31:16]);
  assign y_raw = 32'(s_tdata[47:32]);

  assign rd_id = ram_rdata[EW-1 -: ID_W];
  assign rd_x  = ram_rdata[2*CW-1 -: CW];
  assign rd_y  = ram_rdata[CW-1:0];

  assign out_free = !m_tvalid || m_tready;
  assign room     = (count < CNT_W'(TABLE_DEPTH));

  nps_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and RAM control
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    accept     = 1'b0;
    issue      = 1'b0;
    finish     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = idx[AW-1:0];
    ram_wdata  = {id_q, x_q, y_q};
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          accept     = 1'b1;
          state_next = (count == '0) ? S_DRAIN : S_SCAN;
        end
      end
      S_SCAN: begin
        issue = 1'b1;
        if (idx + 1'b1 == count) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_v && !d_v && !s_v && !t_v) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = S_IDLE;
          if (cmd_q == CMD_INSERT && (hit || room)) begin
            ram_we   = 1'b1;
            ram_addr = hit ? hit_idx : count[AW-1:0];
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Item capture and scan counter
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= s_tuser;
      id_q  <= s_tdata[15:0];
      x_q   <= x_raw[CW-1:0];
      y_q   <= y_raw[CW-1:0];
      idx   <= '0;
    end else if (issue) begin
      idx <= idx + 1'b1;
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (finish && cmd_q == CMD_INSERT && !hit && room) begin
      count <= count + 1'b1;
    end
  end

  // Read beat valid and id match on the RAM output
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      hit  <= 1'b0;
    end else begin
      rd_v <= issue;
      if (accept) begin
        hit <= 1'b0;
      end else if (rd_v && !hit && rd_id == id_q) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= idx[AW-1:0];
    if (rd_v && !hit && rd_id == id_q) begin
      hit_idx <= rd_addr_q;
    end
  end

  // Distance pipeline: differences, squares, sum
  assign px = dx * dx;
  assign py = dy * dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
      s_v <= 1'b0;
      t_v <= 1'b0;
    end else begin
      d_v <= rd_v;
      s_v <= d_v;
      t_v <= s_v;
    end
  end

  always_ff @(posedge clk) begin
    dx   <= (CW + 1)'(x_q) - (CW + 1)'(rd_x);
    dy   <= (CW + 1)'(y_q) - (CW + 1)'(rd_y);
    d_id <= rd_id;
    sqx  <= SQW'($unsigned(px));
    sqy  <= SQW'($unsigned(py));
    s_id <= d_id;
    sum  <= DW'(sqx) + DW'(sqy);
    t_id <= s_id;
  end

  // Running minimum, first stored entry wins ties
  always_ff @(posedge clk) begin
    if (rst) begin
      found_q <= 1'b0;
    end else if (accept) begin
      found_q <= 1'b0;
    end else if (t_v) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (t_v && (!found_q || sum < best)) begin
      best    <= sum;
      best_id <= t_id;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (cmd_q == CMD_QUERY) begin
        m_tuser <= ST_QUERY;
        if (found_q) begin
          m_tdata <= {6'b0, DIST_W'(best), best_id, 1'b1};
        end else begin
          m_tdata <= '0;
        end
      end else begin
        m_tdata <= '0;
        if (hit) begin
          m_tuser <= ST_REPLACED;
        end else if (room) begin
          m_tuser <= ST_ADDED;
        end else begin
          m_tuser <= ST_FULL;
        end
      end
    end
  end

endmodule

// ===== rtl/nps_ram.sv =====
module nps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nps_pkg::*;

  localparam int DEPTH        = TABLE_DEPTH_DEF;
  localparam int PHASE_ITEMS  = 475;
  localparam int DRAIN_CYCLES = DEPTH + 16;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam logic [DIST_W-1:0] DIST_MAX = 33'd8589672450;

  typedef struct packed {
    logic               cmd;
    logic [ID_W-1:0]    id;
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
  } point_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [ID_W-1:0]     nid;
    logic [DIST_W-1:0]   dsq;
  } search_res_t;

  // Directed row: a request plus an optional hand-typed result
  typedef struct packed {
    point_req_t  req;
    logic        typed;
    search_res_t res;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // point_id[15:0], x_coord[31:16], y_coord[47:32]
  logic        s_tuser;   // cmd
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;   // found[0], nearest_id[16:1], best_dist_sq[49:17], zero
  logic [1:0]  m_tuser;   // status

  nearest_point_search_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Point table mirror
  logic [ID_W-1:0]           tbl_id [DEPTH];
  logic signed [FIELD_W-1:0] tbl_x  [DEPTH];
  logic signed [FIELD_W-1:0] tbl_y  [DEPTH];
  int                        tbl_count;

  search_res_t pending_results[$];
  dir_row_t    dir_rows[$];

  int err_count;
  int cycle_count;
  int tx_gap_pct;
  int rx_stall_pct;
  int n_beats, n_added, n_replaced, n_full, n_query, n_query_empty, n_results;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog
  initial begin
    cycle_count = 0;
    wait (cycle_count >= LIMIT_CYCLES);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Apply one request to the table mirror and return the result it yields
  function automatic search_res_t table_apply(point_req_t r);
    search_res_t       res;
    int                hit;
    longint            dx, dy;
    logic [DIST_W-1:0] d;
    res = '0;
    if (r.cmd == CMD_INSERT) begin
      hit = -1;
      for (int i = 0; i < tbl_count; i++) begin
        if (hit < 0 && tbl_id[i] == r.id) hit = i;
      end
      if (hit >= 0) begin
        tbl_x[hit] = r.x;
        tbl_y[hit] = r.y;
        res.status = ST_REPLACED;
        n_replaced++;
      end else if (tbl_count < DEPTH) begin
        tbl_id[tbl_count] = r.id;
        tbl_x[tbl_count]  = r.x;
        tbl_y[tbl_count]  = r.y;
        tbl_count++;
        res.status = ST_ADDED;
        n_added++;
      end else begin
        res.status = ST_FULL;
        n_full++;
      end
    end else begin
      res.status = ST_QUERY;
      n_query++;
      // storage order scan, strict less-than keeps the first of equal distances
      for (int i = 0; i < tbl_count; i++) begin
        dx = longint'($signed(r.x)) - longint'(tbl_x[i]);
        dy = longint'($signed(r.y)) - longint'(tbl_y[i]);
        d  = DIST_W'(dx * dx + dy * dy);
        if (!res.found || d < res.dsq) begin
          res.found = 1'b1;
          res.nid   = tbl_id[i];
          res.dsq   = d;
        end
      end
      if (!res.found) n_query_empty++;
    end
    return res;
  endfunction

  function automatic dir_row_t dir(logic cmd, logic [15:0] id, logic [15:0] x,
                                   logic [15:0] y, logic typed,
                                   logic [STATUS_W-1:0] status = ST_ADDED,
                                   logic found = 1'b0, logic [15:0] nid = '0,
                                   logic [DIST_W-1:0] dsq = '0);
    dir_row_t r;
    r.req   = '{cmd, id, x, y};
    r.typed = typed;
    r.res   = '{status, found, nid, dsq};
    return r;
  endfunction

  // Append one directed row
  function automatic void add_row(dir_row_t r);
    dir_rows = {dir_rows, r};
  endfunction

  // Mostly small coordinates so distances tie often; some full range, some rails
  function automatic logic [15:0] rand_coord();
    int sel;
    logic [15:0] c;
    sel = $urandom_range(0, 9);
    if (sel <= 5) begin
      c = 16'($urandom_range(0, 255)) - 16'd128;
    end else if (sel <= 8) begin
      c = 16'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0:       c = 16'h8000;
        1:       c = 16'h7FFF;
        2:       c = 16'hFFFF;
        default: c = 16'h0000;
      endcase
    end
    return c;
  endfunction

  function automatic point_req_t rand_req();
    point_req_t r;
    int k;
    r.cmd = $urandom_range(0, 1) ? CMD_QUERY : CMD_INSERT;
    r.id  = 16'($urandom);
    r.x   = rand_coord();
    r.y   = rand_coord();
    if (tbl_count > 0) begin
      k = $urandom_range(0, tbl_count - 1);
      // reuse a stored id so replaces keep coming once the table is full
      if (r.cmd == CMD_INSERT && $urandom_range(0, 99) < 35) r.id = tbl_id[k];
      // query close to a stored point
      if (r.cmd == CMD_QUERY && $urandom_range(0, 99) < 25) begin
        r.x = tbl_x[k] + 16'($urandom_range(0, 63)) - 16'd32;
        r.y = tbl_y[k] + 16'($urandom_range(0, 63)) - 16'd32;
      end
    end
    return r;
  endfunction

  // Drive one beat at the falling edge, hold until taken, then predict it
  task automatic send_item(point_req_t r, logic typed, search_res_t typed_res);
    search_res_t pred;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 48'($urandom) ^ {16'($urandom), 32'h0};
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r.y, r.x, r.id};
    s_tuser  <= r.cmd;
    do @(posedge clk); while (!s_tready);
    pred = table_apply(r);
    pending_results = {pending_results, (typed ? typed_res : pred)};
    n_beats++;
  endtask

  // Result side back-pressure
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  task automatic cmp(string name, longint unsigned exp, longint unsigned act);
    if (exp != act) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
      err_count++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    search_res_t exp;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: status %0d data %h", m_tuser, m_tdata);
        err_count++;
      end else begin
        exp = pending_results.pop_front();
        cmp("status", exp.status, m_tuser);
        cmp("found", exp.found, m_tdata[0]);
        cmp("nearest_id", exp.nid, m_tdata[16:1]);
        cmp("best_dist_sq", exp.dsq, m_tdata[49:17]);
        cmp("pad", 0, m_tdata[55:50]);
      end
    end
  end

  initial begin
    int gap_pct[4];
    int stall_pct[4];
    gap_pct   = '{0, 49, 0, 21};
    stall_pct = '{0, 0, 49, 21};
    err_count = 0;
    tbl_count = 0;
    n_beats = 0; n_added = 0; n_replaced = 0; n_full = 0;
    n_query = 0; n_query_empty = 0; n_results = 0;
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = CMD_INSERT;

    // Directed: empty table, distance rails, replace keeps order, ties
    add_row(dir(CMD_QUERY,  16'h1234, 16'h0000, 16'h0000, 1'b1, ST_QUERY));
    add_row(dir(CMD_INSERT, 16'hFFFF, 16'h7FFF, 16'h7FFF, 1'b1, ST_ADDED));
    add_row(dir(CMD_QUERY,  16'h0000, 16'h8000, 16'h8000, 1'b1, ST_QUERY, 1'b1,
                16'hFFFF, DIST_MAX));
    add_row(dir(CMD_INSERT, 16'h0000, 16'h8000, 16'h8000, 1'b1, ST_ADDED));
    add_row(dir(CMD_QUERY,  16'hFFFF, 16'h8000, 16'h8000, 1'b1, ST_QUERY, 1'b1,
                16'h0000, '0));
    add_row(dir(CMD_INSERT, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, ST_REPLACED));
    add_row(dir(CMD_INSERT, 16'h1234, 16'h0000, 16'h0000, 1'b1, ST_ADDED));
    // two points on the same spot: the one stored first answers
    add_row(dir(CMD_QUERY,  16'h0000, 16'h0000, 16'h0000, 1'b1, ST_QUERY, 1'b1,
                16'hFFFF, '0));
    add_row(dir(CMD_INSERT, 16'h00AA, 16'h0020, 16'h0000, 1'b1, ST_ADDED));
    add_row(dir(CMD_QUERY,  16'h0000, 16'h0010, 16'h0000, 1'b0));
    add_row(dir(CMD_INSERT, 16'h0000, 16'h7FFF, 16'h8000, 1'b1, ST_REPLACED));
    add_row(dir(CMD_QUERY,  16'hA5A5, 16'h7FFF, 16'h8000, 1'b1, ST_QUERY, 1'b1,
                16'h0000, '0));
    add_row(dir(CMD_INSERT, 16'h5555, 16'hFFFF, 16'hFFFF, 1'b1, ST_ADDED));
    add_row(dir(CMD_QUERY,  16'h0000, 16'h8000, 16'h7FFF, 1'b0));
    add_row(dir(CMD_INSERT, 16'hAAAA, 16'h0001, 16'hFFFE, 1'b1, ST_ADDED));
    add_row(dir(CMD_QUERY,  16'h0000, 16'h0000, 16'hFFFF, 1'b0));
    add_row(dir(CMD_INSERT, 16'h8000, 16'h5555, 16'hAAAA, 1'b1, ST_ADDED));
    add_row(dir(CMD_INSERT, 16'h7FFF, 16'hAAAA, 16'h5555, 1'b1, ST_ADDED));
    add_row(dir(CMD_QUERY,  16'h0000, 16'h5555, 16'h5555, 1'b0));
    add_row(dir(CMD_QUERY,  16'hFFFF, 16'h7FFF, 16'h7FFF, 1'b0));
    add_row(dir(CMD_INSERT, 16'h1234, 16'h0100, 16'h0100, 1'b1, ST_REPLACED));
    add_row(dir(CMD_QUERY,  16'h0000, 16'h0080, 16'h0080, 1'b0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

    // Random part; the table fills early, after which new ids get rejected
    for (int ph = 0; ph < 4; ph++) begin
      tx_gap_pct   = gap_pct[ph];
      rx_stall_pct = stall_pct[ph];
      repeat (PHASE_ITEMS) send_item(rand_req(), 1'b0, '0);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d beats in, %0d results: %0d added, %0d replaced, %0d rejected (full)",
             n_beats, n_results, n_added, n_replaced, n_full);
    $display("%0d queries (%0d on empty table), idle/stall mixes: none, src, sink, both",
             n_query, n_query_empty);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
